[src/ttce_pkg.sv]
package ttce_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int GLYPH_BITS     = 7;
  localparam int SCREEN_BITS    = 12;
  localparam int TAB_BITS       = 5;
  localparam int ATTR_BITS      = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;
  localparam int REM_BITS       = TAB_BITS;
  localparam int RES_CNT_BITS   = 6;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_BITS-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'd32;

  // most results one byte may cause, and the room a tab space needs
  localparam int MAX_RESULTS    = 48;
  localparam int SPACE_RESULTS  = 3;
  localparam int UNDERLINE_RISE = 2;

  localparam int ATTR_INVERSE   = 0;
  localparam int ATTR_UNDERLINE = 1;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_UNDER  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_GLYPH = 3'd0,
    KIND_BS    = 3'd1,
    KIND_CR    = 3'd2,
    KIND_LF    = 3'd3,
    KIND_TAB   = 3'd4
  } kind_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GLYPH_WIDTH     = 3'd0,
    REG_GLYPH_HEIGHT    = 3'd1,
    REG_SCREEN_WIDTH    = 3'd2,
    REG_SCREEN_HEIGHT   = 3'd3,
    REG_TAB_STOP        = 3'd4,
    REG_FIRST_PRINTABLE = 3'd5,
    REG_LAST_PRINTABLE  = 3'd6,
    REG_TEXT_ATTRIBUTES = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GLYPH_BITS-1:0]  glyph_width;
    logic [GLYPH_BITS-1:0]  glyph_height;
    logic [SCREEN_BITS-1:0] screen_width;
    logic [SCREEN_BITS-1:0] screen_height;
    logic [TAB_BITS-1:0]    tab_stop;
    logic [CHAR_BITS-1:0]   first_printable;
    logic [CHAR_BITS-1:0]   last_printable;
    logic [ATTR_BITS-1:0]   text_attributes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    glyph_width:     7'd8,
    glyph_height:    7'd12,
    screen_width:    12'd640,
    screen_height:   12'd480,
    tab_stop:        5'd4,
    first_printable: 8'd32,
    last_printable:  8'd126,
    text_attributes: 2'd0
  };

  // one classified byte waiting for the back end
  typedef struct packed {
    kind_e                kind;
    logic [CHAR_BITS-1:0] code;
    logic                 wrap;
  } entry_t;

endpackage

[src/ttce_intf.sv]
interface ttce_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface ttce_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [7:0]            glyph;
  logic                  swap_colours;
  logic                  last;

  modport source (output valid, output command, output pos_x, output pos_y,
                  output glyph, output swap_colours, output last, input ready);
  modport sink (input valid, input command, input pos_x, input pos_y,
                input glyph, input swap_colours, input last, output ready);
endinterface

interface ttce_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/ttce_front.sv]
module ttce_front (
  ttce_char_if.sink          char_i,
  input  ttce_pkg::cfg_t     cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output ttce_pkg::entry_t   entry_o
);
  import ttce_pkg::*;

  logic [CHAR_BITS-1:0] code;

  assign code         = char_i.char_code;
  assign char_i.ready = !full_i;
  assign push_o       = char_i.valid && !full_i;

  // wrap test applies to anything the font holds, controls included
  assign entry_o.wrap = (code >= cfg_i.first_printable) && (code <= cfg_i.last_printable);
  assign entry_o.code = code;

  always_comb begin
    unique case (code)
      CHAR_BS:  entry_o.kind = KIND_BS;
      CHAR_CR:  entry_o.kind = KIND_CR;
      CHAR_LF:  entry_o.kind = KIND_LF;
      CHAR_TAB: entry_o.kind = KIND_TAB;
      default:  entry_o.kind = KIND_GLYPH;
    endcase
  end

endmodule

[src/ttce_queue.sv]
module ttce_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ttce_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ttce_pkg::entry_t entry_o
);
  import ttce_pkg::*;

  localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(QUEUE_DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(QUEUE_DEPTH);

  entry_t              slot_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[src/ttce_back.sv]
module ttce_back #(
  parameter int COORD_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ttce_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  ttce_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  ttce_cmd_if.source       cmd_o
);
  import ttce_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = ((CB > SCREEN_BITS) ? CB : SCREEN_BITS) + 2;
  localparam int CW = (CB > 1) ? $clog2(CB) : 1;
  localparam logic [CB-1:0] CoordMax = '1;
  localparam logic [RES_CNT_BITS-1:0] RoomLimit = RES_CNT_BITS'(MAX_RESULTS - SPACE_RESULTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRAP  = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_MODS  = 3'd3;
  localparam logic [2:0] ST_TWRAP = 3'd4;
  localparam logic [2:0] ST_DRAW  = 3'd5;
  localparam logic [2:0] ST_UNDER = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  function automatic logic [CB-1:0] sat_f(input logic [AW-1:0] v);
    logic [CB-1:0] r;
    r = (v > AW'(CoordMax)) ? CoordMax : v[CB-1:0];
    return r;
  endfunction

  logic [2:0]              state_q, state_d;
  logic [CB-1:0]           x_q, x_d, y_q, y_d, col_q, col_d;
  logic [CHAR_BITS-1:0]    code_q, code_d;
  kind_e                   kind_q, kind_d;
  logic                    wrap_q, wrap_d;
  logic [REM_BITS-1:0]     rem_q, rem_d;
  logic [CB-1:0]           div_q, div_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [RES_CNT_BITS-1:0] res_cnt_q, res_cnt_d;

  logic                    pend_v_q, pend_v_d;
  cmd_e                    pend_cmd_q;
  logic [CB-1:0]           pend_x_q, pend_y_q;
  logic [CHAR_BITS-1:0]    pend_glyph_q;
  logic                    pend_swap_q;

  logic                    out_v_q, out_v_d;
  cmd_e                    out_cmd_q;
  logic [CB-1:0]           out_x_q, out_y_q;
  logic [CHAR_BITS-1:0]    out_glyph_q;
  logic                    out_swap_q, out_last_q;

  logic                    emit, emit_go, flush, push_out, out_free, emit_ok;
  cmd_e                    em_cmd;
  logic [CB-1:0]           em_x, em_y;
  logic [CHAR_BITS-1:0]    em_glyph;
  logic                    em_swap;

  logic [AW-1:0]           x_a, y_a, gw_a, gh_a, sw_a, sh_a, ul_sum;
  logic                    x_over, lf_scroll, space_ok, wrap_hit, in_tab, ul_on;
  logic [CB-1:0]           y_inc, x_glyph, col_inc, x_bs, ul_y;
  logic [TAB_BITS-1:0]     tab_eff, rem_plus;
  logic [REM_BITS:0]       mod_part;
  logic [REM_BITS-1:0]     rem_adv, mod_next;

  // shared cursor arithmetic
  assign x_a  = AW'(x_q);
  assign y_a  = AW'(y_q);
  assign gw_a = AW'(cfg_i.glyph_width);
  assign gh_a = AW'(cfg_i.glyph_height);
  assign sw_a = AW'(cfg_i.screen_width);
  assign sh_a = AW'(cfg_i.screen_height);

  assign x_over    = (x_a + gw_a) > sw_a;
  assign lf_scroll = (y_a + (gh_a << 1)) > sh_a;
  assign y_inc     = sat_f(y_a + gh_a);
  assign x_glyph   = sat_f(x_a + gw_a);
  assign col_inc   = (col_q == CoordMax) ? col_q : col_q + 1'b1;
  assign x_bs      = (x_a >= gw_a) ? CB'(x_a - gw_a) : '0;
  assign ul_sum    = y_a + gh_a;
  assign ul_y      = sat_f((ul_sum >= AW'(UNDERLINE_RISE)) ? ul_sum - AW'(UNDERLINE_RISE) : '0);

  assign space_ok = (CHAR_SPACE >= cfg_i.first_printable) && (CHAR_SPACE <= cfg_i.last_printable);
  assign wrap_hit = x_over && ((state_q == ST_TWRAP) ? space_ok : wrap_q);
  assign in_tab   = (kind_q == KIND_TAB);
  assign ul_on    = cfg_i.text_attributes[ATTR_UNDERLINE];

  // column modulo tab stop, kept as a running remainder
  assign tab_eff  = (cfg_i.tab_stop == '0) ? TAB_BITS'(1) : cfg_i.tab_stop;
  assign rem_plus = TAB_BITS'(rem_q) + 1'b1;
  assign rem_adv  = (col_q == CoordMax) ? rem_q :
                    (rem_plus == tab_eff) ? '0 : rem_plus[REM_BITS-1:0];
  assign mod_part = {rem_q, div_q[CB-1]};
  assign mod_next = (mod_part >= (REM_BITS+1)'(tab_eff)) ?
                    REM_BITS'(mod_part - (REM_BITS+1)'(tab_eff)) : mod_part[REM_BITS-1:0];

  // result hand-off: pending word waits until the next one proves it is not last
  assign out_free = !out_v_q || cmd_o.ready;
  assign emit_ok  = !pend_v_q || out_free;

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    col_d     = col_q;
    code_d    = code_q;
    kind_d    = kind_q;
    wrap_d    = wrap_q;
    rem_d     = rem_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    res_cnt_d = res_cnt_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    flush     = 1'b0;
    em_cmd    = CMD_DRAW;
    em_x      = x_q;
    em_y      = y_q;
    em_glyph  = code_q;
    em_swap   = cfg_i.text_attributes[ATTR_INVERSE];

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          code_d    = q_entry_i.code;
          kind_d    = q_entry_i.kind;
          wrap_d    = q_entry_i.wrap;
          res_cnt_d = '0;
          state_d   = ST_WRAP;
        end
      end
      ST_WRAP, ST_TWRAP: begin
        if (state_q == ST_TWRAP && res_cnt_q > RoomLimit) begin
          state_d = ST_DONE;
        end else begin
          if (wrap_hit) begin
            x_d   = '0;
            col_d = '0;
            if (lf_scroll) begin
              emit     = 1'b1;
              em_cmd   = CMD_SCROLL;
              em_x     = '0;
              em_y     = '0;
              em_glyph = '0;
              em_swap  = 1'b0;
            end else begin
              y_d = y_inc;
            end
          end
          if (state_q == ST_TWRAP) begin
            if (wrap_hit) begin
              rem_d = '0;
            end
            state_d = ST_DRAW;
          end else begin
            unique case (kind_q)
              KIND_BS, KIND_CR, KIND_LF: state_d = ST_ACT;
              KIND_GLYPH: state_d = ST_DRAW;
              KIND_TAB: begin
                code_d  = CHAR_SPACE;
                div_d   = wrap_hit ? '0 : col_q;
                cnt_d   = CW'(CB - 1);
                rem_d   = '0;
                state_d = ST_MODS;
              end
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_ACT: begin
        unique case (kind_q)
          KIND_BS: begin
            x_d   = x_bs;
            col_d = (col_q == '0) ? '0 : col_q - 1'b1;
          end
          KIND_CR: begin
            x_d   = '0;
            col_d = '0;
          end
          KIND_LF: begin
            if (lf_scroll) begin
              emit     = 1'b1;
              em_cmd   = CMD_SCROLL;
              em_x     = '0;
              em_y     = '0;
              em_glyph = '0;
              em_swap  = 1'b0;
            end else begin
              y_d = y_inc;
            end
          end
          default: ;
        endcase
        state_d = ST_DONE;
      end
      ST_MODS: begin
        rem_d = mod_next;
        div_d = div_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_TWRAP;
        end
      end
      ST_DRAW: begin
        emit  = 1'b1;
        x_d   = x_glyph;
        col_d = col_inc;
        if (in_tab) begin
          rem_d = rem_adv;
        end
        if (ul_on) begin
          state_d = ST_UNDER;
        end else if (in_tab && rem_adv != '0) begin
          state_d = ST_TWRAP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UNDER: begin
        emit     = 1'b1;
        em_cmd   = CMD_UNDER;
        em_x     = pend_x_q;
        em_y     = ul_y;
        em_glyph = '0;
        state_d  = (in_tab && rem_q != '0) ? ST_TWRAP : ST_DONE;
      end
      ST_DONE: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          flush   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // no room downstream: hold everything for this cycle
    if (emit && !emit_ok) begin
      state_d = state_q;
      x_d     = x_q;
      y_d     = y_q;
      col_d   = col_q;
      code_d  = code_q;
      rem_d   = rem_q;
    end else if (emit) begin
      res_cnt_d = res_cnt_q + 1'b1;
    end
  end

  assign emit_go  = emit && emit_ok;
  assign push_out = (emit_go && pend_v_q) || flush;

  always_comb begin
    pend_v_d = pend_v_q;
    if (emit_go) begin
      pend_v_d = 1'b1;
    end else if (flush) begin
      pend_v_d = 1'b0;
    end
    out_v_d = out_v_q && !cmd_o.ready;
    if (push_out) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      x_q       <= '0;
      y_q       <= '0;
      col_q     <= '0;
      kind_q    <= KIND_GLYPH;
      wrap_q    <= 1'b0;
      rem_q     <= '0;
      cnt_q     <= '0;
      res_cnt_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      x_q       <= x_d;
      y_q       <= y_d;
      col_q     <= col_d;
      kind_q    <= kind_d;
      wrap_q    <= wrap_d;
      rem_q     <= rem_d;
      cnt_q     <= cnt_d;
      res_cnt_q <= res_cnt_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    div_q  <= div_d;
    if (push_out) begin
      out_cmd_q   <= pend_cmd_q;
      out_x_q     <= pend_x_q;
      out_y_q     <= pend_y_q;
      out_glyph_q <= pend_glyph_q;
      out_swap_q  <= pend_swap_q;
      out_last_q  <= flush;
    end
    if (emit_go) begin
      pend_cmd_q   <= em_cmd;
      pend_x_q     <= em_x;
      pend_y_q     <= em_y;
      pend_glyph_q <= em_glyph;
      pend_swap_q  <= em_swap;
    end
  end

  assign cmd_o.valid        = out_v_q;
  assign cmd_o.command      = out_cmd_q;
  assign cmd_o.pos_x        = out_x_q;
  assign cmd_o.pos_y        = out_y_q;
  assign cmd_o.glyph        = out_glyph_q;
  assign cmd_o.swap_colours = out_swap_q;
  assign cmd_o.last         = out_last_q;

endmodule

[src/text_terminal_cursor_engine.sv]
// channel  | dir | handshake        | word
// ---------+-----+------------------+----------------------------------------------
// char_i   | in  | valid/ready      | char_code, one byte to print or control
// cmd_o    | out | valid/ready      | command, pos_x, pos_y, glyph, swap_colours,
//          |     |                  | last (set on the final word of a byte)
// cfg_i    | in  | valid/ready      | index, data; ready is always high
//
// a plain byte steps through wrap, draw, underline when on, and done in the back end;
// backspace, carriage return and line feed may give no word at all
// a tab first works out the column modulo tab stop, one bit a cycle, then draws
// spaces, each with its underline when on, until the stop or until it runs out of
// room for words
// reset clears the cursor, the column and the queue, and loads register defaults
// a stalled cmd_o holds the back end; the two-word queue keeps char_i open meanwhile
module text_terminal_cursor_engine #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttce_char_if.sink   char_i,
  ttce_cmd_if.source  cmd_o,
  ttce_cfg_if.sink    cfg_i
);
  import ttce_pkg::*;

  cfg_t   cfg_q;
  logic   push, full, q_valid, q_pop;
  entry_t push_entry, q_entry;

  // register file; the user must write it only while the engine is idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_GLYPH_WIDTH:     cfg_q.glyph_width     <= cfg_i.data[GLYPH_BITS-1:0];
        REG_GLYPH_HEIGHT:    cfg_q.glyph_height    <= cfg_i.data[GLYPH_BITS-1:0];
        REG_SCREEN_WIDTH:    cfg_q.screen_width    <= cfg_i.data[SCREEN_BITS-1:0];
        REG_SCREEN_HEIGHT:   cfg_q.screen_height   <= cfg_i.data[SCREEN_BITS-1:0];
        REG_TAB_STOP:        cfg_q.tab_stop        <= cfg_i.data[TAB_BITS-1:0];
        REG_FIRST_PRINTABLE: cfg_q.first_printable <= cfg_i.data[CHAR_BITS-1:0];
        REG_LAST_PRINTABLE:  cfg_q.last_printable  <= cfg_i.data[CHAR_BITS-1:0];
        REG_TEXT_ATTRIBUTES: cfg_q.text_attributes <= cfg_i.data[ATTR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front end: classify the byte and flag whether it is subject to the wrap test
  ttce_front u_front (
    .char_i  (char_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // short queue so the input side keeps taking bytes while results drain
  ttce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // back end: cursor state, tab stepping and the result words
  ttce_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .cmd_o     (cmd_o)
  );

endmodule

[tb/text_terminal_cursor_engine_tb.sv]
module text_terminal_cursor_engine_tb;
  import ttce_pkg::*;

  localparam int          COORD_BITS  = 12;
  localparam int unsigned COORD_MAX   = (1 << COORD_BITS) - 1;
  // receiver hold-off long enough to fill the two-word queue and block char_i
  localparam int          LONG_HOLD   = 300;
  // a no-word byte may still sit in the queue or back end once the last word is in
  localparam int          IDLE_TAIL   = 40;
  localparam int          DRAIN_LIMIT = 20000;

  // one word on cmd_o as the renderer sees it
  typedef struct packed {
    cmd_e                  command;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [CHAR_BITS-1:0]  glyph;
    logic                  swap_colours;
    logic                  last;
  } cmd_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttce_char_if                            char_bus ();
  ttce_cmd_if #(.COORD_BITS(COORD_BITS))  cmd_bus ();
  ttce_cfg_if                             cfg_bus ();

  text_terminal_cursor_engine #(.COORD_BITS(COORD_BITS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .cmd_o  (cmd_bus),
    .cfg_i  (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the registers and the cursor, updated as bytes are accepted
  cfg_t        shadow_cfg;
  int unsigned cur_x;
  int unsigned cur_y;
  int unsigned cur_col;

  // words caused by the byte in hand, then all words still owed by the block
  cmd_word_t   byte_words[$];
  cmd_word_t   pending_words[$];

  int          mismatches     = 0;
  int          words_checked  = 0;
  int          bytes_sent     = 0;
  int          tabs_sent      = 0;
  int          scrolls_owed   = 0;
  int          most_words     = 0;
  int          settings_used  = 0;

  // sender bursts and receiver stall pattern
  bit          sender_gaps    = 1'b1;
  int          burst_left     = 0;
  bit          sink_stalls    = 1'b1;
  int          run_left       = 0;
  int          hold_left      = 0;
  int          holdoffs_asked = 0;
  int          holdoffs_done  = 0;

  function automatic int unsigned clamp_coord(int unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // the block never gives more than MAX_RESULTS words for one byte
  function automatic void push_word(cmd_e c, int unsigned x, int unsigned y,
                                    logic [CHAR_BITS-1:0] g, logic sw);
    cmd_word_t w;
    if (byte_words.size() >= MAX_RESULTS) return;
    w.command      = c;
    w.pos_x        = x[COORD_BITS-1:0];
    w.pos_y        = y[COORD_BITS-1:0];
    w.glyph        = g;
    w.swap_colours = sw;
    w.last         = 1'b0;
    byte_words.push_back(w);
  endfunction

  // new line: scroll when the next text row would not fit, else move down
  function automatic void advance_line();
    int unsigned gh = 32'(shadow_cfg.glyph_height);
    if (cur_y + 2 * gh > shadow_cfg.screen_height) begin
      push_word(CMD_SCROLL, 0, 0, '0, 1'b0);
      scrolls_owed++;
    end else begin
      cur_y = clamp_coord(cur_y + gh);
    end
  endfunction

  // bytes the font holds wrap to a new line before crossing the right edge
  function automatic void wrap_if_full(logic [CHAR_BITS-1:0] code);
    if (code >= shadow_cfg.first_printable && code <= shadow_cfg.last_printable &&
        cur_x + shadow_cfg.glyph_width > shadow_cfg.screen_width) begin
      cur_x   = 0;
      cur_col = 0;
      advance_line();
    end
  endfunction

  function automatic void draw_cell(logic [CHAR_BITS-1:0] code);
    logic        inv = shadow_cfg.text_attributes[ATTR_INVERSE];
    int unsigned rule_y;
    push_word(CMD_DRAW, cur_x, cur_y, code, inv);
    if (shadow_cfg.text_attributes[ATTR_UNDERLINE]) begin
      rule_y = cur_y + shadow_cfg.glyph_height;
      rule_y = (rule_y >= UNDERLINE_RISE) ? rule_y - UNDERLINE_RISE : 0;
      push_word(CMD_UNDER, cur_x, clamp_coord(rule_y), '0, inv);
    end
    cur_x   = clamp_coord(cur_x + shadow_cfg.glyph_width);
    cur_col = clamp_coord(cur_col + 1);
  endfunction

  // works out the words one accepted byte causes and queues them
  function automatic void plan_char_words(logic [CHAR_BITS-1:0] code);
    int unsigned gw   = 32'(shadow_cfg.glyph_width);
    int unsigned stop = (shadow_cfg.tab_stop == 0) ? 1 : 32'(shadow_cfg.tab_stop);
    byte_words.delete();
    wrap_if_full(code);
    case (code)
      CHAR_BS: begin
        cur_x   = (cur_x >= gw) ? cur_x - gw : 0;
        cur_col = (cur_col != 0) ? cur_col - 1 : 0;
      end
      CHAR_CR: begin
        cur_x   = 0;
        cur_col = 0;
      end
      CHAR_LF: begin
        advance_line();
      end
      CHAR_TAB: begin
        tabs_sent++;
        // at least one space; gives up when a further space might not fit
        while (byte_words.size() + SPACE_RESULTS <= MAX_RESULTS) begin
          wrap_if_full(CHAR_SPACE);
          draw_cell(CHAR_SPACE);
          if (cur_col % stop == 0) break;
        end
      end
      default: begin
        draw_cell(code);
      end
    endcase
    if (byte_words.size() != 0) byte_words[byte_words.size() - 1].last = 1'b1;
    if (byte_words.size() > most_words) most_words = byte_words.size();
    foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
  endfunction

  // offers one byte and waits for it to be taken; the sender works in bursts
  task automatic send_char(input logic [CHAR_BITS-1:0] code);
    int gap;
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= code;
    do @(posedge clk_i); while (!char_bus.ready);
    plan_char_words(code);
    bytes_sent++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
        char_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // one register write; valid is left high so writes can follow back to back
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_GLYPH_WIDTH:     shadow_cfg.glyph_width     = value[GLYPH_BITS-1:0];
      REG_GLYPH_HEIGHT:    shadow_cfg.glyph_height    = value[GLYPH_BITS-1:0];
      REG_SCREEN_WIDTH:    shadow_cfg.screen_width    = value[SCREEN_BITS-1:0];
      REG_SCREEN_HEIGHT:   shadow_cfg.screen_height   = value[SCREEN_BITS-1:0];
      REG_TAB_STOP:        shadow_cfg.tab_stop        = value[TAB_BITS-1:0];
      REG_FIRST_PRINTABLE: shadow_cfg.first_printable = value[CHAR_BITS-1:0];
      REG_LAST_PRINTABLE:  shadow_cfg.last_printable  = value[CHAR_BITS-1:0];
      REG_TEXT_ATTRIBUTES: shadow_cfg.text_attributes = value[ATTR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(REG_GLYPH_WIDTH,     CFG_DATA_BITS'(s.glyph_width));
    write_reg(REG_GLYPH_HEIGHT,    CFG_DATA_BITS'(s.glyph_height));
    write_reg(REG_SCREEN_WIDTH,    s.screen_width);
    write_reg(REG_SCREEN_HEIGHT,   s.screen_height);
    write_reg(REG_TAB_STOP,        CFG_DATA_BITS'(s.tab_stop));
    write_reg(REG_FIRST_PRINTABLE, CFG_DATA_BITS'(s.first_printable));
    write_reg(REG_LAST_PRINTABLE,  CFG_DATA_BITS'(s.last_printable));
    write_reg(REG_TEXT_ATTRIBUTES, CFG_DATA_BITS'(s.text_attributes));
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // sender stops until every owed word is in, then lets trailing no-word bytes drain
  task automatic wait_idle();
    int waited = 0;
    char_bus.valid <= 1'b0;
    while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  function automatic int unsigned edge_pick(int unsigned lo, int unsigned hi);
    int r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.glyph_width     = GLYPH_BITS'(edge_pick(1, 64));
    s.glyph_height    = GLYPH_BITS'(edge_pick(1, 64));
    s.screen_width    = SCREEN_BITS'(edge_pick(1, 4095));
    s.screen_height   = SCREEN_BITS'(edge_pick(1, 4095));
    s.tab_stop        = TAB_BITS'(edge_pick(1, 16));
    s.first_printable = CHAR_BITS'(edge_pick(0, 255));
    s.last_printable  = CHAR_BITS'(edge_pick(0, 255));
    s.text_attributes = ATTR_BITS'($urandom_range(0, 3));
    return s;
  endfunction

  // control codes at the given percent, any byte for ten percent more or an empty font, else a font byte
  function automatic logic [CHAR_BITS-1:0] pick_char(int ctrl_pct);
    int r = $urandom_range(0, 99);
    if (r < ctrl_pct) begin
      case ($urandom_range(0, 3))
        0:       return CHAR_TAB;
        1:       return CHAR_LF;
        2:       return CHAR_CR;
        default: return CHAR_BS;
      endcase
    end
    if (r < ctrl_pct + 10 || shadow_cfg.first_printable > shadow_cfg.last_printable)
      return CHAR_BITS'($urandom_range(0, 255));
    return CHAR_BITS'($urandom_range(32'(shadow_cfg.last_printable),
                                     32'(shadow_cfg.first_printable)));
  endfunction

  task automatic run_traffic(input cfg_t s, input int count, input int ctrl_pct);
    wait_idle();
    load_settings(s);
    repeat (count) send_char(pick_char(ctrl_pct));
  endtask

  // reset values of every register: a tab, line feed, carriage return, three backspaces, code extremes
  task automatic test_default_settings();
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_TAB);
    send_char(CHAR_BS);
    send_char(CHAR_BS);
    send_char(CHAR_CR);
    send_char(CHAR_BS);
    send_char(CHAR_LF);
  endtask

  // wide glyphs on a tiny surface: wrap with scroll, controls inside the font
  // range wrapping first, and a tab that runs out of room for words
  task automatic test_wrap_and_scroll();
    cfg_t s;
    s = '{glyph_width: 7'd64, glyph_height: 7'd64, screen_width: 12'd100,
          screen_height: 12'd100, tab_stop: 5'd16, first_printable: 8'd0,
          last_printable: 8'd255, text_attributes: 2'd3};
    wait_idle();
    load_settings(s);
    send_char(8'h4D);
    send_char(8'h4E);
    send_char(CHAR_TAB);
    send_char(CHAR_BS);
    send_char(CHAR_LF);
    send_char(CHAR_CR);
  endtask

  // zero glyph width, zero tab stop, tallest glyph, then an empty font range
  task automatic test_odd_sizes();
    cfg_t s;
    s = '{glyph_width: 7'd0, glyph_height: 7'd127, screen_width: 12'd1,
          screen_height: 12'd4095, tab_stop: 5'd0, first_printable: 8'd0,
          last_printable: 8'd255, text_attributes: 2'd1};
    wait_idle();
    load_settings(s);
    send_char(8'h61);
    send_char(CHAR_TAB);
    send_char(CHAR_LF);
    send_char(CHAR_BS);
    send_char(8'hFF);
    s.glyph_width     = 7'd64;
    s.first_printable = 8'd200;
    s.last_printable  = 8'd100;
    wait_idle();
    load_settings(s);
    send_char(8'h71);
    send_char(8'h72);
  endtask

  // random settings, one phase without any idling on either side
  task automatic test_mixed_traffic();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_traffic(random_settings(), 80, 30);
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_traffic(random_settings(), 80, 30);
    run_traffic(random_settings(), 60, 30);
  endtask

  // one-pixel cells on a one-pixel surface: nearly every glyph wraps and scrolls
  task automatic test_tiny_screen();
    cfg_t s;
    s = '{glyph_width: 7'd1, glyph_height: 7'd1, screen_width: 12'd1,
          screen_height: 12'd1, tab_stop: 5'd1, first_printable: 8'd0,
          last_printable: 8'd255, text_attributes: 2'd2};
    run_traffic(s, 70, 25);
  endtask

  // the receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    cfg_t s;
    s = '{glyph_width: 7'd64, glyph_height: 7'd64, screen_width: 12'd4095,
          screen_height: 12'd4095, tab_stop: 5'd16, first_printable: 8'd32,
          last_printable: 8'd126, text_attributes: 2'd3};
    wait_idle();
    load_settings(s);
    sender_gaps = 1'b0;
    holdoffs_asked++;
    repeat (80) send_char(pick_char(20));
    sender_gaps = 1'b1;
  endtask

  // no byte wraps, so a long run of glyphs drives the cursor into saturation
  task automatic test_cursor_saturation();
    cfg_t s;
    s = '{glyph_width: 7'd64, glyph_height: 7'd8, screen_width: 12'd640,
          screen_height: 12'd4095, tab_stop: 5'd8, first_printable: 8'd255,
          last_printable: 8'd0, text_attributes: 2'd0};
    run_traffic(s, 90, 2);
  endtask

  // receiver: runs of ready and stall, long hold-offs on request, or always ready
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      cmd_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holdoffs_done != holdoffs_asked) begin
      cmd_bus.ready <= 1'b0;
      hold_left     <= LONG_HOLD;
      holdoffs_done <= holdoffs_done + 1;
    end else if (!sink_stalls) begin
      cmd_bus.ready <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else begin
      cmd_bus.ready <= ~cmd_bus.ready;
      run_left      <= cmd_bus.ready ? $urandom_range(0, 4) : $urandom_range(0, 10);
    end
  end

  // every word taken on cmd_o must match the oldest word still owed
  always @(posedge clk_i) begin
    cmd_word_t got;
    cmd_word_t want;
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      got.command      = cmd_e'(cmd_bus.command);
      got.pos_x        = cmd_bus.pos_x;
      got.pos_y        = cmd_bus.pos_y;
      got.glyph        = cmd_bus.glyph;
      got.swap_colours = cmd_bus.swap_colours;
      got.last         = cmd_bus.last;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t unexpected word, expected none, got %0d/%0d/%0d/%0d/%0d/%0d",
                 $time, got.command, got.pos_x, got.pos_y, got.glyph,
                 got.swap_colours, got.last);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t expected %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d %s",
                   $time, want.command, want.pos_x, want.pos_y, want.glyph,
                   want.swap_colours, want.last, got.command, got.pos_x, got.pos_y,
                   got.glyph, got.swap_colours, got.last, "(cmd/x/y/glyph/swap/last)");
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_GLYPH_WIDTH;
    cfg_bus.data       = '0;
    cmd_bus.ready      = 1'b0;
    shadow_cfg         = CFG_RESET;
    cur_x              = 0;
    cur_y              = 0;
    cur_col            = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_settings();
    test_wrap_and_scroll();
    test_odd_sizes();
    test_mixed_traffic();
    test_tiny_screen();
    test_backpressure();
    test_cursor_saturation();

    wait_idle();
    if (pending_words.size() != 0) begin
      mismatches++;
      $display("%0t %0d words still expected, got none", $time, pending_words.size());
    end
    $display("sent %0d bytes (%0d tabs) under %0d register settings",
             bytes_sent, tabs_sent, settings_used + 1);
    $display("checked %0d words, %0d scrolls, at most %0d words from one byte",
             words_checked, scrolls_owed, most_words);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
